@@ rtl/rva_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the
// axis-angle vector rotation pipeline. No dependencies.
package rva_pkg;

	localparam int VEC_W   = 32;
	localparam int AXIS_W  = 16;
	localparam int ANGLE_W = 32;

	localparam int CORDIC_STEPS = 18;
	localparam int XW = 34;
	localparam int ZW = 26;

	localparam int DEG_HALF    = 180;
	localparam int DEG_FULL    = 2 * DEG_HALF;
	localparam int DEG_QUARTER = DEG_HALF / 2;
	localparam int FRAC_ONE    = 65536;

	localparam logic [24:0] FULL_TURN = 25'(DEG_FULL * FRAC_ONE);
	localparam logic signed [ZW-1:0] HALF_TURN_S    = ZW'(DEG_HALF * FRAC_ONE);
	localparam logic signed [ZW-1:0] FULL_TURN_S    = ZW'(DEG_FULL * FRAC_ONE);
	localparam logic signed [ZW-1:0] QUARTER_TURN_S = ZW'(DEG_QUARTER * FRAC_ONE);
	localparam logic signed [ZW-1:0] THREE_Q_TURN_S = ZW'(3 * DEG_QUARTER * FRAC_ONE);

	localparam logic [33:0] ANG_OFFSET = 34'(64'd92 * 64'(DEG_FULL * FRAC_ONE));
	localparam int RECIP_SHIFT = 25;
	localparam logic [16:0] RECIP_360 = 17'(((64'd1 << RECIP_SHIFT) + 64'(DEG_FULL) - 64'd1)
		/ 64'(DEG_FULL));

	localparam logic signed [XW-1:0] CORDIC_K = XW'(652032874);
	localparam logic signed [XW-1:0] ONE_Q30  = XW'(64'd1 << 30);

	// stage numbers
	localparam int ST_FOLD   = 4;
	localparam int ST_CORDIC = 5;
	localparam int ST_TRIG   = ST_CORDIC + CORDIC_STEPS;
	localparam int ST_MULT   = ST_TRIG + 1;
	localparam int ST_MAT    = ST_MULT + 1;
	localparam int ST_PROD   = ST_MAT + 1;
	localparam int NUM_STAGES = ST_PROD + 1;

	typedef struct packed {
		logic signed [VEC_W-1:0]   vec_x;
		logic signed [VEC_W-1:0]   vec_y;
		logic signed [VEC_W-1:0]   vec_z;
		logic signed [AXIS_W-1:0]  axis_x;
		logic signed [AXIS_W-1:0]  axis_y;
		logic signed [AXIS_W-1:0]  axis_z;
		logic signed [ANGLE_W-1:0] angle_degrees;
	} item_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] rot_x;
		logic signed [VEC_W-1:0] rot_y;
		logic signed [VEC_W-1:0] rot_z;
	} result_t;

	typedef struct packed {
		logic signed [VEC_W-1:0]  vec_x;
		logic signed [VEC_W-1:0]  vec_y;
		logic signed [VEC_W-1:0]  vec_z;
		logic signed [AXIS_W-1:0] axis_x;
		logic signed [AXIS_W-1:0] axis_y;
		logic signed [AXIS_W-1:0] axis_z;
		logic                     neg_cos;
	} side_t;

	// atan(2^-i) in Q16.16 degrees
	function automatic logic signed [ZW-1:0] atan_deg(input int unsigned step);
		logic signed [ZW-1:0] t;
		case (step)
			0:  t = ZW'(2949120);
			1:  t = ZW'(1740967);
			2:  t = ZW'(919879);
			3:  t = ZW'(466945);
			4:  t = ZW'(234379);
			5:  t = ZW'(117304);
			6:  t = ZW'(58666);
			7:  t = ZW'(29335);
			8:  t = ZW'(14668);
			9:  t = ZW'(7334);
			10: t = ZW'(3667);
			11: t = ZW'(1833);
			12: t = ZW'(917);
			13: t = ZW'(458);
			14: t = ZW'(229);
			15: t = ZW'(115);
			16: t = ZW'(57);
			17: t = ZW'(29);
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/rva_chan_if.sv @@
// Valid/ready channel carrying one word of a given payload type.
// Payload types come from rva_pkg at the point of instantiation.
interface rva_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rotate_vector_about_axis.sv @@
// Axis-angle (Rodrigues) rotation of a Q16.16 vector; top level.
// Depends on rva_pkg and rva_chan_if.
// The pipeline is made of the 18 CORDIC stages, the four angle-reduction stages
// and five matrix stages.
// Throughput: one word per cycle while result.ready is high; else a word enters only if any stage is empty.
// Reset clears the stage valid bits only; the datapath registers are not reset.
module rotate_vector_about_axis (
	input  logic clk,
	input  logic arst_n,
	rva_chan_if.sink   item,
	rva_chan_if.source result
);

	localparam int NS = rva_pkg::NUM_STAGES;
	localparam int XW = rva_pkg::XW;
	localparam int ZW = rva_pkg::ZW;
	localparam int CS = rva_pkg::CORDIC_STEPS;

	logic [NS:1] vld_s;
	logic [NS:1] adv;

	rva_pkg::side_t side_s [1:rva_pkg::ST_PROD];

	// angle reduction
	logic [33:0]          ang_off;
	logic [16:0]          h_s1, h_s2;
	logic [15:0]          lo_s1, lo_s2;
	logic [33:0]          q_prod;
	logic [8:0]           q_s2;
	logic [16:0]          rem;
	logic [24:0]          a_s3;
	logic signed [ZW-1:0] a_ext;
	logic signed [ZW-1:0] fold_z;
	logic                 fold_neg;
	logic signed [ZW-1:0] z_s4;

	// CORDIC
	logic signed [XW-1:0] cx_s [CS];
	logic signed [XW-1:0] cy_s [CS];
	logic signed [ZW-1:0] cz_s [CS];
	logic signed [XW-1:0] xin [CS];
	logic signed [XW-1:0] yin [CS];
	logic signed [ZW-1:0] zin [CS];

	// matrix
	logic signed [XW-1:0] cos_c;
	logic signed [XW-1:0] c_s23, s_s23, omc_s23;
	logic signed [31:0]   aa_xx_s23, aa_yy_s23, aa_zz_s23, aa_xy_s23, aa_xz_s23, aa_yz_s23;
	logic signed [31:0]   cd_s24;
	logic signed [31:0]   sxx_s24, syy_s24, szz_s24, sxy_s24, sxz_s24, syz_s24;
	logic signed [31:0]   snx_s24, sny_s24, snz_s24;
	logic signed [65:0]   sym_xx, sym_yy, sym_zz, sym_xy, sym_xz, sym_yz;
	logic signed [49:0]   sin_x, sin_y, sin_z;
	logic signed [31:0]   m_s25 [3][3];
	logic signed [63:0]   p_s26 [3][3];
	logic signed [31:0]   vec_col [3];
	logic signed [65:0]   acc [3];
	logic signed [39:0]   shr [3];
	logic signed [31:0]   rot_s27 [3];

	// a stage may advance when result.ready is high or when it or any stage after it is empty
	for (genvar k = 1; k <= NS; k++) begin : g_adv
		assign adv[k] = result.ready | ~(&vld_s[NS:k]);
	end

	assign item.ready   = adv[1];
	assign result.valid = vld_s[NS];
	assign result.data.rot_x = rot_s27[0];
	assign result.data.rot_y = rot_s27[1];
	assign result.data.rot_z = rot_s27[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= item.valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// vector and axis travel alongside the angle work
	always_ff @(posedge clk) begin
		rva_pkg::side_t side_nxt;
		if (adv[1]) begin
			side_s[1].vec_x   <= item.data.vec_x;
			side_s[1].vec_y   <= item.data.vec_y;
			side_s[1].vec_z   <= item.data.vec_z;
			side_s[1].axis_x  <= item.data.axis_x;
			side_s[1].axis_y  <= item.data.axis_y;
			side_s[1].axis_z  <= item.data.axis_z;
			side_s[1].neg_cos <= 1'b0;
		end
		for (int k = 2; k <= rva_pkg::ST_PROD; k++) begin
			if (adv[k]) begin
				side_nxt = side_s[k-1];
				if (k == rva_pkg::ST_FOLD) begin
					side_nxt.neg_cos = fold_neg;
				end
				side_s[k] <= side_nxt;
			end
		end
	end

	// stage 1: shift the angle positive by a multiple of 360 degrees
	assign ang_off = {{2{item.data.angle_degrees[31]}}, item.data.angle_degrees}
		+ rva_pkg::ANG_OFFSET;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			h_s1  <= ang_off[32:16];
			lo_s1 <= ang_off[15:0];
		end
	end

	// stage 2: whole degrees divided by 360 through the reciprocal
	assign q_prod = 34'(h_s1) * 34'(rva_pkg::RECIP_360);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			q_s2  <= q_prod[rva_pkg::RECIP_SHIFT +: 9];
			h_s2  <= h_s1;
			lo_s2 <= lo_s1;
		end
	end

	// stage 3: remainder, angle in [0, 360)
	assign rem = h_s2 - 17'(q_s2) * 17'(rva_pkg::DEG_FULL);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			a_s3 <= {rem[8:0], lo_s2};
		end
	end

	// stage 4: fold into [-90, 90], flag cosine negation
	assign a_ext = ZW'({1'b0, a_s3});

	always_comb begin
		if (a_ext <= rva_pkg::QUARTER_TURN_S) begin
			fold_z   = a_ext;
			fold_neg = 1'b0;
		end else if (a_ext < rva_pkg::THREE_Q_TURN_S) begin
			fold_z   = rva_pkg::HALF_TURN_S - a_ext;
			fold_neg = 1'b1;
		end else begin
			fold_z   = a_ext - rva_pkg::FULL_TURN_S;
			fold_neg = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[rva_pkg::ST_FOLD]) begin
			z_s4 <= fold_z;
		end
	end

	// CORDIC, one micro-rotation per stage
	always_comb begin
		xin[0] = rva_pkg::CORDIC_K;
		yin[0] = '0;
		zin[0] = z_s4;
		for (int i = 1; i < CS; i++) begin
			xin[i] = cx_s[i-1];
			yin[i] = cy_s[i-1];
			zin[i] = cz_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CS; i++) begin
			if (adv[rva_pkg::ST_CORDIC + i]) begin
				if (zin[i] >= 0) begin
					cx_s[i] <= xin[i] - (yin[i] >>> i);
					cy_s[i] <= yin[i] + (xin[i] >>> i);
					cz_s[i] <= zin[i] - rva_pkg::atan_deg(i);
				end else begin
					cx_s[i] <= xin[i] + (yin[i] >>> i);
					cy_s[i] <= yin[i] - (xin[i] >>> i);
					cz_s[i] <= zin[i] + rva_pkg::atan_deg(i);
				end
			end
		end
	end

	// trig stage: cosine sign, one minus cosine, axis products
	assign cos_c = side_s[rva_pkg::ST_TRIG-1].neg_cos ? -cx_s[CS-1] : cx_s[CS-1];

	always_ff @(posedge clk) begin
		if (adv[rva_pkg::ST_TRIG]) begin
			c_s23     <= cos_c;
			s_s23     <= cy_s[CS-1];
			omc_s23   <= rva_pkg::ONE_Q30 - cos_c;
			aa_xx_s23 <= 32'(side_s[rva_pkg::ST_TRIG-1].axis_x)
				* 32'(side_s[rva_pkg::ST_TRIG-1].axis_x);
			aa_yy_s23 <= 32'(side_s[rva_pkg::ST_TRIG-1].axis_y)
				* 32'(side_s[rva_pkg::ST_TRIG-1].axis_y);
			aa_zz_s23 <= 32'(side_s[rva_pkg::ST_TRIG-1].axis_z)
				* 32'(side_s[rva_pkg::ST_TRIG-1].axis_z);
			aa_xy_s23 <= 32'(side_s[rva_pkg::ST_TRIG-1].axis_x)
				* 32'(side_s[rva_pkg::ST_TRIG-1].axis_y);
			aa_xz_s23 <= 32'(side_s[rva_pkg::ST_TRIG-1].axis_x)
				* 32'(side_s[rva_pkg::ST_TRIG-1].axis_z);
			aa_yz_s23 <= 32'(side_s[rva_pkg::ST_TRIG-1].axis_y)
				* 32'(side_s[rva_pkg::ST_TRIG-1].axis_z);
		end
	end

	// multiply stage: symmetric and sine terms
	assign sym_xx = 66'(aa_xx_s23) * 66'(omc_s23);
	assign sym_yy = 66'(aa_yy_s23) * 66'(omc_s23);
	assign sym_zz = 66'(aa_zz_s23) * 66'(omc_s23);
	assign sym_xy = 66'(aa_xy_s23) * 66'(omc_s23);
	assign sym_xz = 66'(aa_xz_s23) * 66'(omc_s23);
	assign sym_yz = 66'(aa_yz_s23) * 66'(omc_s23);
	assign sin_x  = 50'(side_s[rva_pkg::ST_MULT-1].axis_x) * 50'(s_s23);
	assign sin_y  = 50'(side_s[rva_pkg::ST_MULT-1].axis_y) * 50'(s_s23);
	assign sin_z  = 50'(side_s[rva_pkg::ST_MULT-1].axis_z) * 50'(s_s23);

	always_ff @(posedge clk) begin
		if (adv[rva_pkg::ST_MULT]) begin
			cd_s24  <= 32'(c_s23 >>> 4);
			sxx_s24 <= 32'(sym_xx >>> 32);
			syy_s24 <= 32'(sym_yy >>> 32);
			szz_s24 <= 32'(sym_zz >>> 32);
			sxy_s24 <= 32'(sym_xy >>> 32);
			sxz_s24 <= 32'(sym_xz >>> 32);
			syz_s24 <= 32'(sym_yz >>> 32);
			snx_s24 <= 32'(sin_x >>> 18);
			sny_s24 <= 32'(sin_y >>> 18);
			snz_s24 <= 32'(sin_z >>> 18);
		end
	end

	// matrix stage
	always_ff @(posedge clk) begin
		if (adv[rva_pkg::ST_MAT]) begin
			m_s25[0][0] <= cd_s24 + sxx_s24;
			m_s25[0][1] <= sxy_s24 - snz_s24;
			m_s25[0][2] <= sxz_s24 + sny_s24;
			m_s25[1][0] <= sxy_s24 + snz_s24;
			m_s25[1][1] <= cd_s24 + syy_s24;
			m_s25[1][2] <= syz_s24 - snx_s24;
			m_s25[2][0] <= sxz_s24 - sny_s24;
			m_s25[2][1] <= syz_s24 + snx_s24;
			m_s25[2][2] <= cd_s24 + szz_s24;
		end
	end

	// product stage
	assign vec_col[0] = side_s[rva_pkg::ST_PROD-1].vec_x;
	assign vec_col[1] = side_s[rva_pkg::ST_PROD-1].vec_y;
	assign vec_col[2] = side_s[rva_pkg::ST_PROD-1].vec_z;

	always_ff @(posedge clk) begin
		if (adv[rva_pkg::ST_PROD]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					p_s26[r][c] <= 64'(m_s25[r][c]) * 64'(vec_col[c]);
				end
			end
		end
	end

	// output stage: sum, round half up, saturate
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = 66'(p_s26[r][0]) + 66'(p_s26[r][1]) + 66'(p_s26[r][2])
				+ 66'(64'sd1 << 25);
			shr[r] = 40'(acc[r] >>> 26);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS]) begin
			for (int r = 0; r < 3; r++) begin
				if (shr[r] > 40'sd2147483647) begin
					rot_s27[r] <= 32'sh7FFF_FFFF;
				end else if (shr[r] < -40'sd2147483648) begin
					rot_s27[r] <= 32'sh8000_0000;
				end else begin
					rot_s27[r] <= shr[r][31:0];
				end
			end
		end
	end

endmodule

@@ tb/rotate_vector_about_axis_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rotate_vector_about_axis: directed and random vector/axis/angle
// words against a behavioural Rodrigues rotation with fold-and-CORDIC trig.
// Depends on rva_pkg and rva_chan_if from the RTL.
module rotate_vector_about_axis_test;

	localparam int     DEG           = 65536;
	localparam longint HALF_REV      = 180 * 65536;
	localparam longint FULL_REV      = 2 * HALF_REV;
	localparam longint QUARTER_REV   = HALF_REV / 2;
	localparam longint GAIN_Q30      = 652032874;
	localparam int     TRIG_STEPS    = 18;
	localparam longint SAT_HI        = (longint'(1) <<< 31) - 1;
	localparam longint SAT_LO        = -(longint'(1) <<< 31);
	localparam int     RANDOM_WORDS  = 1200;
	localparam int     SETTLE_CYCLES = 40;
	localparam int     CYCLE_LIMIT   = 600000;

	typedef struct {
		rva_pkg::item_t word;
		bit             drain;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n;

	rva_chan_if #(.payload_t(rva_pkg::item_t))   item_ch ();
	rva_chan_if #(.payload_t(rva_pkg::result_t)) result_ch ();

	rotate_vector_about_axis DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	longint  arctan_deg [0:TRIG_STEPS-1] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
	};

	stim_t            pending_words [$];
	rva_pkg::result_t expected_rot_q [$];
	int               words_sent;
	int               results_seen;
	int               mismatches;
	int               drains;
	int               cycle_count;
	int               send_idle;
	int               recv_stall;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic signed [31:0] rotated_row(input longint m0, m1, m2, vx, vy, vz);
		longint acc;
		acc = (m0 * vx + m1 * vy + m2 * vz + (longint'(1) <<< 25)) >>> 26;
		if (acc > SAT_HI)
			acc = SAT_HI;
		else if (acc < SAT_LO)
			acc = SAT_LO;
		return 32'(acc);
	endfunction

	function automatic rva_pkg::result_t rotate_predict(input rva_pkg::item_t w);
		longint  vx, vy, vz, ax, ay, az;
		longint  a, x, y, z, dx, dy, c, s, omc, cd;
		longint  m [0:8];
		bit      flip;
		rva_pkg::result_t r;
		vx = longint'($signed(w.vec_x));
		vy = longint'($signed(w.vec_y));
		vz = longint'($signed(w.vec_z));
		ax = longint'($signed(w.axis_x));
		ay = longint'($signed(w.axis_y));
		az = longint'($signed(w.axis_z));
		a = longint'($signed(w.angle_degrees)) % FULL_REV;
		if (a < 0)
			a += FULL_REV;
		if (a > HALF_REV)
			a -= FULL_REV;
		flip = 1'b0;
		if (a > QUARTER_REV) begin
			a = HALF_REV - a;
			flip = 1'b1;
		end else if (a < -QUARTER_REV) begin
			a = -HALF_REV - a;
			flip = 1'b1;
		end
		x = GAIN_Q30;
		y = 0;
		z = a;
		for (int i = 0; i < TRIG_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= arctan_deg[i];
			end else begin
				x += dx;
				y -= dy;
				z += arctan_deg[i];
			end
		end
		c = flip ? -x : x;
		s = y;
		omc = (longint'(1) <<< 30) - c;
		cd = c >>> 4;
		m[0] = cd + ((ax * ax * omc) >>> 32);
		m[1] = ((ax * ay * omc) >>> 32) - ((az * s) >>> 18);
		m[2] = ((ax * az * omc) >>> 32) + ((ay * s) >>> 18);
		m[3] = ((ay * ax * omc) >>> 32) + ((az * s) >>> 18);
		m[4] = cd + ((ay * ay * omc) >>> 32);
		m[5] = ((ay * az * omc) >>> 32) - ((ax * s) >>> 18);
		m[6] = ((az * ax * omc) >>> 32) - ((ay * s) >>> 18);
		m[7] = ((az * ay * omc) >>> 32) + ((ax * s) >>> 18);
		m[8] = cd + ((az * az * omc) >>> 32);
		r.rot_x = rotated_row(m[0], m[1], m[2], vx, vy, vz);
		r.rot_y = rotated_row(m[3], m[4], m[5], vx, vy, vz);
		r.rot_z = rotated_row(m[6], m[7], m[8], vx, vy, vz);
		return r;
	endfunction

	function automatic int pick_idle();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want, got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d (%h), got %0d (%h)",
				$time, name, want, want, got, got);
		end
	endtask

	task automatic queue_word(input logic signed [31:0] vx, vy, vz,
			input logic signed [15:0] ax, ay, az, input logic signed [31:0] ang,
			input bit drain);
		stim_t st;
		st.word.vec_x         = vx;
		st.word.vec_y         = vy;
		st.word.vec_z         = vz;
		st.word.axis_x        = ax;
		st.word.axis_y        = ay;
		st.word.axis_z        = az;
		st.word.angle_degrees = ang;
		st.drain              = drain;
		pending_words.push_back(st);
	endtask

	// sender: hold a word until taken, then pop and predict
	always @(posedge clk) begin
		bit holding;
		bit next_valid;
		int idle;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			send_idle <= 0;
		end else begin
			holding = item_ch.valid && !item_ch.ready;
			next_valid = 1'b0;
			idle = send_idle;
			if (item_ch.valid && item_ch.ready) begin
				expected_rot_q.push_back(rotate_predict(item_ch.data));
				void'(pending_words.pop_front());
				words_sent++;
				if ((words_sent / 100) % 5 != 4 && $urandom_range(0, 3) == 0)
					idle = pick_idle();
			end else if (holding) begin
				next_valid = 1'b1;
			end else if (idle > 0) begin
				idle = idle - 1;
			end
			if (!holding && idle == 0 && pending_words.size() != 0) begin
				if (!pending_words[0].drain || expected_rot_q.size() == 0) begin
					next_valid = 1'b1;
					item_ch.data <= pending_words[0].word;
					if (pending_words[0].drain)
						drains++;
				end
			end
			send_idle <= idle;
			item_ch.valid <= next_valid;
		end
	end

	// receiver: check each taken word against the oldest prediction
	always @(posedge clk) begin
		rva_pkg::result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (expected_rot_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, got %h", $time,
						result_ch.data);
				end else begin
					want = expected_rot_q.pop_front();
					check_field("rot_x", want.rot_x, result_ch.data.rot_x);
					check_field("rot_y", want.rot_y, result_ch.data.rot_y);
					check_field("rot_z", want.rot_z, result_ch.data.rot_z);
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				result_ch.ready <= 1'b0;
			end else if ((cycle_count / 2000) % 4 != 3 && $urandom_range(0, 4) == 0) begin
				recv_stall <= pick_idle() - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int   kind;
		int   span;
		real  rx, ry, rz, norm;
		logic signed [31:0] v [0:2];
		logic signed [15:0] ax, ay, az;
		logic signed [31:0] ang;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		words_sent = 0;
		results_seen = 0;
		mismatches = 0;
		drains = 0;
		cycle_count = 0;

		// quadrant folds, wrap points and angle extremes about unit axes
		queue_word(0, 0, 0, 0, 0, 16384, 0, 0);
		queue_word(DEG, 0, 0, 0, 0, 16384, 90 * DEG, 0);
		queue_word(DEG, 2 * DEG, 0, 0, 0, 16384, 90 * DEG + 1, 0);
		queue_word(DEG, -DEG, 3 * DEG, 0, 0, 16384, -90 * DEG, 0);
		queue_word(DEG, -DEG, 3 * DEG, 0, 0, 16384, -90 * DEG - 1, 0);
		queue_word(5 * DEG, 7 * DEG, -2 * DEG, 16384, 0, 0, 180 * DEG, 0);
		queue_word(5 * DEG, 7 * DEG, -2 * DEG, 0, 16384, 0, -180 * DEG, 0);
		queue_word(5 * DEG, 7 * DEG, -2 * DEG, 0, -16384, 0, 180 * DEG + 1, 0);
		queue_word(-3 * DEG, DEG, DEG, 0, 0, -16384, 270 * DEG, 0);
		queue_word(-3 * DEG, DEG, DEG, -16384, 0, 0, 360 * DEG, 0);
		queue_word(0, DEG, DEG, 16384, 0, 0, 45 * DEG, 0);
		queue_word(12345, -6789, 1 << 20, 0, 16384, 0, 32'sh7FFF_FFFF, 0);
		queue_word(12345, -6789, 1 << 20, 0, 16384, 0, 32'sh8000_0000, 0);
		// full-scale vectors, saturation and non-unit axes
		queue_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16384, 0, 0, 0, 0);
		queue_word(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, -16384, 0, 30 * DEG, 0);
		queue_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			16'sh8000, 16'sh8000, 16'sh8000, 180 * DEG, 0);
		queue_word(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			16'sh7FFF, 0, 16'sh8000, 180 * DEG, 0);
		queue_word(40 * DEG, -40 * DEG, 8 * DEG, 0, 0, 0, 60 * DEG, 0);
		queue_word(40 * DEG, -40 * DEG, 8 * DEG, 16384, 16384, 16384, 120 * DEG, 0);
		queue_word(32'sh7FFF_FFFF, 0, 0, 0, 0, 16384, 90 * DEG, 0);
		queue_word(-1, -1, -1, 9459, 9459, 9459, 135 * DEG, 0);
		queue_word(DEG, DEG, 0, 0, 0, 16384, -45 * DEG, 0);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				rx = real'(int'($urandom_range(0, 2000)) - 1000);
				ry = real'(int'($urandom_range(0, 2000)) - 1000);
				rz = real'(int'($urandom_range(0, 2000)) - 1000);
				norm = $sqrt(rx * rx + ry * ry + rz * rz);
				if (norm < 1.0) begin
					rz = 1.0;
					norm = 1.0;
				end
				ax = 16'($rtoi(rx / norm * 16384.0));
				ay = 16'($rtoi(ry / norm * 16384.0));
				az = 16'($rtoi(rz / norm * 16384.0));
			end else if (kind < 16) begin
				ax = 16'sd0;
				ay = 16'sd0;
				az = 16'sd0;
				case ($urandom_range(0, 2))
					0: ax = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
					1: ay = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
					default: az = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
				endcase
			end else if (kind < 18) begin
				ax = 16'(int'($urandom_range(0, 32768)) - 16384);
				ay = 16'(int'($urandom_range(0, 32768)) - 16384);
				az = 16'(int'($urandom_range(0, 32768)) - 16384);
			end else begin
				ax = 16'($urandom);
				ay = 16'($urandom);
				az = 16'($urandom);
			end
			for (int k = 0; k < 3; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					v[k] = $urandom;
				end else begin
					span = 1 << $urandom_range(0, 24);
					v[k] = int'($urandom_range(0, 2 * span)) - span;
				end
			end
			case ($urandom_range(0, 5))
				0, 1: ang = $urandom;
				5: ang = (int'($urandom_range(0, 16)) - 8) * 90 * DEG
					+ int'($urandom_range(0, 2)) - 1;
				default: ang = int'($urandom_range(0, 1440 * DEG)) - 720 * DEG;
			endcase
			queue_word(v[0], v[1], v[2], ax, ay, az, ang,
				n == 0 || $urandom_range(0, 149) == 0);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_words.size() != 0 || expected_rot_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d vector/axis/angle words (%0d after a full drain), checked %0d results",
			words_sent, drains, results_seen);
		$display("Covered fold boundaries, angle wrap, saturation and non-unit axes; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
